// ===== hw/rtl/dts_pkg.sv =====
// shared types and constants of the dependency scheduler
// no dependencies; used by the interfaces, controller, datapath and top level
package dts_pkg;

    // default sizes
    localparam int MAX_PASSES_DEF = 16;
    localparam int MAX_DEPS_DEF   = 32;
    localparam int KEY_BITS_DEF   = 16;

    // fixed field widths of the channels
    localparam int ACT_W  = 2;
    localparam int KIND_W = 2;
    localparam int IDX_W  = 4;
    localparam int DIAG_W = 3;
    localparam int SLOT_W = 5;
    localparam int CNT_W  = 5;

    // action codes
    localparam logic [ACT_W-1:0] ACT_DECL   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DEP    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FINISH = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_SCHED   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DIAG    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LEFT    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd3;

    // diagnostic codes
    localparam logic [DIAG_W-1:0] DIAG_NONE     = 3'd0;
    localparam logic [DIAG_W-1:0] DIAG_ID_MISS  = 3'd1;
    localparam logic [DIAG_W-1:0] DIAG_DUP      = 3'd2;
    localparam logic [DIAG_W-1:0] DIAG_REF_MISS = 3'd3;
    localparam logic [DIAG_W-1:0] DIAG_UNKNOWN  = 3'd4;
    localparam logic [DIAG_W-1:0] DIAG_SELF     = 3'd5;
    localparam logic [DIAG_W-1:0] DIAG_CYCLE    = 3'd6;
    localparam logic [DIAG_W-1:0] DIAG_OVERFLOW = 3'd7;

    // controller states
    typedef enum logic [5:0] {
        T_IDLE, T_DISPATCH,
        T_D_CHK, T_D_OVF, T_D_MISS, T_D_RD, T_D_CMP, T_D_DUP, T_D_WR,
        T_A_CHK, T_A_KRD, T_A_OVF, T_A_WR,
        T_F_CLR,
        T_R_RD, T_R_TAKE, T_R_SRD, T_R_SCMP, T_R_KEYD, T_R_DIAG, T_R_DEGRD, T_R_EDGE,
        T_R_NEXT,
        T_Q_RD, T_Q_PUSH,
        T_K_POP, T_K_CUR, T_K_EMIT, T_K_SRD, T_K_CHK, T_K_DEC, T_K_END,
        T_C_RD, T_C_CHK, T_C_EMIT, T_SUM
    } t_state;

    // datapath micro-operations
    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_KEY_SCAN_RD, OP_KEY_SCAN_CMP, OP_DECL_WR,
        OP_KEY_RD_LAST, OP_DEP_WR, OP_DEG_CLR, OP_S_ZERO, OP_DEP_RD,
        OP_DEP_TAKE, OP_KEY_RD_CONS, OP_DEG_RD_CONS, OP_EDGE_WR, OP_S_INC,
        OP_I_ZERO, OP_DEG_RD_I, OP_FIFO_PUSH_I, OP_FIFO_RD, OP_CUR_TAKE,
        OP_DEG_RD_CQ, OP_DEC, OP_I_INC
    } t_op;

    // result beats the datapath can form
    typedef enum logic [3:0] {
        EM_NONE, EM_OVF_DECL, EM_ID_MISS, EM_DUP, EM_OVF_DEP, EM_DEP_DIAG,
        EM_SCHED, EM_CYCLE, EM_LEFT, EM_SUMMARY
    } t_emit;

    typedef struct packed {
        logic  in_ready;
        t_op   op;
        t_emit emit;
    } t_cmd;

    typedef struct packed {
        logic             in_fire;
        logic [ACT_W-1:0] act;
        logic             is_out;
        logic             pcnt_zero;
        logic             pcnt_full;
        logic             dcnt_full;
        logic             tgt_zero;
        logic             i_lt_p;
        logic             found;
        logic             p_eq_cons;
        logic             s_lt_d;
        logic             rq_zero;
        logic             head_lt_tail;
        logic             sched_lt_p;
        logic             edge_hit;
        logic             dq_nz;
        logic             out_free;
    } t_status;

endpackage

// ===== hw/rtl/dts_in_if.sv =====
// input channel of the dependency scheduler: valid, ready and the request fields
// depends on dts_pkg
interface dts_in_if #(
    parameter int KEY_BITS = dts_pkg::KEY_BITS_DEF
);
    logic                      valid;
    logic                      ready;
    logic [dts_pkg::ACT_W-1:0] action;
    logic [KEY_BITS-1:0]       pass_key;
    logic [KEY_BITS-1:0]       ref_key;
    logic                      ref_is_pass_output;

    modport source (output valid, action, pass_key, ref_key, ref_is_pass_output,
                    input ready);
    modport sink   (input valid, action, pass_key, ref_key, ref_is_pass_output,
                    output ready);
endinterface

// ===== hw/rtl/dts_out_if.sv =====
// output channel of the dependency scheduler: valid, ready and the result fields
// depends on dts_pkg
interface dts_out_if #(
    parameter int KEY_BITS = dts_pkg::KEY_BITS_DEF
);
    logic                       valid;
    logic                       ready;
    logic [dts_pkg::KIND_W-1:0] kind;
    logic [dts_pkg::IDX_W-1:0]  pass_index;
    logic [KEY_BITS-1:0]        pass_key_out;
    logic [dts_pkg::DIAG_W-1:0] diag_code;
    logic [dts_pkg::SLOT_W-1:0] dep_slot;
    logic [dts_pkg::CNT_W-1:0]  scheduled_count;
    logic                       success;
    logic                       last;

    modport source (output valid, kind, pass_index, pass_key_out, diag_code, dep_slot,
                    scheduled_count, success, last, input ready);
    modport sink   (input valid, kind, pass_index, pass_key_out, diag_code, dep_slot,
                    scheduled_count, success, last, output ready);
endinterface

// ===== hw/rtl/dts_ctrl.sv =====
// controller state machine of the dependency scheduler
// depends on dts_pkg; drives datapath commands from datapath status
module dts_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dts_pkg::t_status i_status,
    output dts_pkg::t_cmd    o_cmd
);
    dts_pkg::t_state  r_state;
    dts_pkg::t_state  n_state;
    dts_pkg::t_status st;

    assign st = i_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dts_pkg::T_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dts_pkg::T_IDLE:     if (st.in_fire) n_state = dts_pkg::T_DISPATCH;
            dts_pkg::T_DISPATCH: begin
                priority case (st.act)
                    dts_pkg::ACT_DECL:   n_state = dts_pkg::T_D_CHK;
                    dts_pkg::ACT_DEP:    n_state = dts_pkg::T_A_CHK;
                    dts_pkg::ACT_FINISH: n_state = dts_pkg::T_F_CLR;
                    default:             n_state = dts_pkg::T_IDLE;
                endcase
            end
            dts_pkg::T_D_CHK: begin
                priority if (st.pcnt_full) n_state = dts_pkg::T_D_OVF;
                else if (st.tgt_zero)      n_state = dts_pkg::T_D_MISS;
                else                       n_state = dts_pkg::T_D_RD;
            end
            dts_pkg::T_D_OVF:  if (st.out_free) n_state = dts_pkg::T_IDLE;
            dts_pkg::T_D_MISS: if (st.out_free) n_state = dts_pkg::T_D_WR;
            dts_pkg::T_D_RD: begin
                priority if (st.found)   n_state = dts_pkg::T_D_DUP;
                else if (st.i_lt_p)      n_state = dts_pkg::T_D_CMP;
                else                     n_state = dts_pkg::T_D_WR;
            end
            dts_pkg::T_D_CMP:  n_state = dts_pkg::T_D_RD;
            dts_pkg::T_D_DUP:  if (st.out_free) n_state = dts_pkg::T_D_WR;
            dts_pkg::T_D_WR:   n_state = dts_pkg::T_IDLE;
            dts_pkg::T_A_CHK: begin
                priority if (!st.is_out || st.pcnt_zero) n_state = dts_pkg::T_IDLE;
                else if (st.dcnt_full)                   n_state = dts_pkg::T_A_KRD;
                else                                     n_state = dts_pkg::T_A_WR;
            end
            dts_pkg::T_A_KRD:  n_state = dts_pkg::T_A_OVF;
            dts_pkg::T_A_OVF:  if (st.out_free) n_state = dts_pkg::T_IDLE;
            dts_pkg::T_A_WR:   n_state = dts_pkg::T_IDLE;
            dts_pkg::T_F_CLR:  if (!st.i_lt_p) n_state = dts_pkg::T_R_RD;
            dts_pkg::T_R_RD:   n_state = st.s_lt_d ? dts_pkg::T_R_TAKE : dts_pkg::T_Q_RD;
            dts_pkg::T_R_TAKE: n_state = st.rq_zero ? dts_pkg::T_R_KEYD : dts_pkg::T_R_SRD;
            dts_pkg::T_R_SRD: begin
                priority if (st.found)
                    n_state = st.p_eq_cons ? dts_pkg::T_R_KEYD : dts_pkg::T_R_DEGRD;
                else if (st.i_lt_p) n_state = dts_pkg::T_R_SCMP;
                else                n_state = dts_pkg::T_R_KEYD;
            end
            dts_pkg::T_R_SCMP:  n_state = dts_pkg::T_R_SRD;
            dts_pkg::T_R_KEYD:  n_state = dts_pkg::T_R_DIAG;
            dts_pkg::T_R_DIAG:  if (st.out_free) n_state = dts_pkg::T_R_NEXT;
            dts_pkg::T_R_DEGRD: n_state = dts_pkg::T_R_EDGE;
            dts_pkg::T_R_EDGE:  n_state = dts_pkg::T_R_NEXT;
            dts_pkg::T_R_NEXT:  n_state = dts_pkg::T_R_RD;
            dts_pkg::T_Q_RD:    n_state = st.i_lt_p ? dts_pkg::T_Q_PUSH : dts_pkg::T_K_POP;
            dts_pkg::T_Q_PUSH:  n_state = dts_pkg::T_Q_RD;
            dts_pkg::T_K_POP:
                n_state = st.head_lt_tail ? dts_pkg::T_K_CUR : dts_pkg::T_K_END;
            dts_pkg::T_K_CUR:   n_state = dts_pkg::T_K_EMIT;
            dts_pkg::T_K_EMIT:  if (st.out_free) n_state = dts_pkg::T_K_SRD;
            dts_pkg::T_K_SRD:   n_state = st.s_lt_d ? dts_pkg::T_K_CHK : dts_pkg::T_K_POP;
            dts_pkg::T_K_CHK:   n_state = st.edge_hit ? dts_pkg::T_K_DEC : dts_pkg::T_K_SRD;
            dts_pkg::T_K_DEC:   n_state = dts_pkg::T_K_SRD;
            dts_pkg::T_K_END: begin
                priority if (!st.sched_lt_p) n_state = dts_pkg::T_SUM;
                else if (st.out_free)        n_state = dts_pkg::T_C_RD;
                else                         n_state = dts_pkg::T_K_END;
            end
            dts_pkg::T_C_RD:   n_state = st.i_lt_p ? dts_pkg::T_C_CHK : dts_pkg::T_SUM;
            dts_pkg::T_C_CHK:  n_state = st.dq_nz ? dts_pkg::T_C_EMIT : dts_pkg::T_C_RD;
            dts_pkg::T_C_EMIT: if (st.out_free) n_state = dts_pkg::T_C_RD;
            dts_pkg::T_SUM:    if (st.out_free) n_state = dts_pkg::T_IDLE;
            default:           n_state = dts_pkg::T_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd.in_ready = 1'b0;
        o_cmd.op       = dts_pkg::OP_NONE;
        o_cmd.emit     = dts_pkg::EM_NONE;
        unique case (r_state)
            dts_pkg::T_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (st.in_fire) o_cmd.op = dts_pkg::OP_LOAD;
            end
            dts_pkg::T_D_OVF:  if (st.out_free) o_cmd.emit = dts_pkg::EM_OVF_DECL;
            dts_pkg::T_D_MISS: if (st.out_free) o_cmd.emit = dts_pkg::EM_ID_MISS;
            dts_pkg::T_D_RD:   if (!st.found && st.i_lt_p) o_cmd.op = dts_pkg::OP_KEY_SCAN_RD;
            dts_pkg::T_D_CMP:  o_cmd.op = dts_pkg::OP_KEY_SCAN_CMP;
            dts_pkg::T_D_DUP:  if (st.out_free) o_cmd.emit = dts_pkg::EM_DUP;
            dts_pkg::T_D_WR:   o_cmd.op = dts_pkg::OP_DECL_WR;
            dts_pkg::T_A_KRD:  o_cmd.op = dts_pkg::OP_KEY_RD_LAST;
            dts_pkg::T_A_OVF:  if (st.out_free) o_cmd.emit = dts_pkg::EM_OVF_DEP;
            dts_pkg::T_A_WR:   o_cmd.op = dts_pkg::OP_DEP_WR;
            dts_pkg::T_F_CLR:
                o_cmd.op = st.i_lt_p ? dts_pkg::OP_DEG_CLR : dts_pkg::OP_S_ZERO;
            dts_pkg::T_R_RD:
                o_cmd.op = st.s_lt_d ? dts_pkg::OP_DEP_RD : dts_pkg::OP_I_ZERO;
            dts_pkg::T_R_TAKE: o_cmd.op = dts_pkg::OP_DEP_TAKE;
            dts_pkg::T_R_SRD:  if (!st.found && st.i_lt_p) o_cmd.op = dts_pkg::OP_KEY_SCAN_RD;
            dts_pkg::T_R_SCMP: o_cmd.op = dts_pkg::OP_KEY_SCAN_CMP;
            dts_pkg::T_R_KEYD: o_cmd.op = dts_pkg::OP_KEY_RD_CONS;
            dts_pkg::T_R_DIAG: if (st.out_free) o_cmd.emit = dts_pkg::EM_DEP_DIAG;
            dts_pkg::T_R_DEGRD: o_cmd.op = dts_pkg::OP_DEG_RD_CONS;
            dts_pkg::T_R_EDGE: o_cmd.op = dts_pkg::OP_EDGE_WR;
            dts_pkg::T_R_NEXT: o_cmd.op = dts_pkg::OP_S_INC;
            dts_pkg::T_Q_RD:   if (st.i_lt_p) o_cmd.op = dts_pkg::OP_DEG_RD_I;
            dts_pkg::T_Q_PUSH: o_cmd.op = dts_pkg::OP_FIFO_PUSH_I;
            dts_pkg::T_K_POP:  if (st.head_lt_tail) o_cmd.op = dts_pkg::OP_FIFO_RD;
            dts_pkg::T_K_CUR:  o_cmd.op = dts_pkg::OP_CUR_TAKE;
            dts_pkg::T_K_EMIT: if (st.out_free) o_cmd.emit = dts_pkg::EM_SCHED;
            dts_pkg::T_K_SRD:  if (st.s_lt_d) o_cmd.op = dts_pkg::OP_DEP_RD;
            dts_pkg::T_K_CHK:
                o_cmd.op = st.edge_hit ? dts_pkg::OP_DEG_RD_CQ : dts_pkg::OP_S_INC;
            dts_pkg::T_K_DEC:  o_cmd.op = dts_pkg::OP_DEC;
            dts_pkg::T_K_END:
                if (st.sched_lt_p && st.out_free) o_cmd.emit = dts_pkg::EM_CYCLE;
            dts_pkg::T_C_RD:   if (st.i_lt_p) o_cmd.op = dts_pkg::OP_DEG_RD_I;
            dts_pkg::T_C_CHK:
                o_cmd.op = st.dq_nz ? dts_pkg::OP_KEY_SCAN_RD : dts_pkg::OP_I_INC;
            dts_pkg::T_C_EMIT: if (st.out_free) o_cmd.emit = dts_pkg::EM_LEFT;
            dts_pkg::T_SUM:    if (st.out_free) o_cmd.emit = dts_pkg::EM_SUMMARY;
            default:           o_cmd.op = dts_pkg::OP_NONE;
        endcase
    end
endmodule

// ===== hw/rtl/dts_dp.sv =====
// datapath of the dependency scheduler: key, dependency, in-degree and ready memories,
// counters and the output register; depends on dts_pkg, dts_in_if and dts_out_if
module dts_dp #(
    parameter int MAX_PASSES = dts_pkg::MAX_PASSES_DEF,
    parameter int MAX_DEPS   = dts_pkg::MAX_DEPS_DEF,
    parameter int KEY_BITS   = dts_pkg::KEY_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    dts_in_if.sink           i_in,
    dts_out_if.source        o_out,
    input  dts_pkg::t_cmd    i_cmd,
    output dts_pkg::t_status o_status
);
    localparam int PI    = $clog2(MAX_PASSES);
    localparam int DI    = $clog2(MAX_DEPS);
    localparam int DEG_W = $clog2(MAX_DEPS + 1);
    localparam int IW    = dts_pkg::IDX_W;
    localparam int SW    = dts_pkg::SLOT_W;
    localparam int CW    = dts_pkg::CNT_W;

    // memories
    logic [KEY_BITS-1:0] m_key  [MAX_PASSES];
    logic [PI-1:0]       m_cons [MAX_DEPS];
    logic [KEY_BITS-1:0] m_ref  [MAX_DEPS];
    logic [PI:0]         m_prod [MAX_DEPS];
    logic [DEG_W-1:0]    m_deg  [MAX_PASSES];
    logic [PI-1:0]       m_fifo [MAX_PASSES];

    // registered read data
    logic [KEY_BITS-1:0] r_kq, r_rq;
    logic [PI-1:0]       r_cq, r_fq;
    logic [PI:0]         r_pq;
    logic [DEG_W-1:0]    r_dq;

    // control and working registers
    logic [dts_pkg::ACT_W-1:0] r_act;
    logic                      r_isout;
    logic [KEY_BITS-1:0]       r_tgt, r_ref;
    logic [PI:0]               r_i, r_pcnt, r_head, r_tail, r_sched;
    logic [DI:0]               r_s, r_dcnt;
    logic                      r_err, r_found;
    logic [PI-1:0]             r_p, r_cons, r_cur;

    // output register
    logic                       r_o_valid;
    logic [dts_pkg::KIND_W-1:0] r_o_kind;
    logic [IW-1:0]              r_o_idx;
    logic [KEY_BITS-1:0]        r_o_key;
    logic [dts_pkg::DIAG_W-1:0] r_o_code;
    logic [SW-1:0]              r_o_slot;
    logic [CW-1:0]              r_o_cnt;
    logic                       r_o_ok, r_o_last;

    logic                       out_free, key_rd;
    logic [PI:0]                pcnt_m1;
    logic [PI-1:0]              key_raddr, deg_raddr, deg_waddr, fifo_wdata;
    logic                       deg_rd, deg_we, fifo_we;
    logic [DEG_W-1:0]           deg_wdata;
    logic [dts_pkg::KIND_W-1:0] e_kind;
    logic [IW-1:0]              e_idx;
    logic [KEY_BITS-1:0]        e_key;
    logic [dts_pkg::DIAG_W-1:0] e_code, dep_code;
    logic [SW-1:0]              e_slot;
    logic                       e_err;

    assign out_free = !r_o_valid || o_out.ready;
    assign pcnt_m1  = r_pcnt - 1'b1;

    // key memory
    always_comb begin
        key_rd    = 1'b1;
        key_raddr = r_i[PI-1:0];
        unique case (i_cmd.op)
            dts_pkg::OP_KEY_SCAN_RD: key_raddr = r_i[PI-1:0];
            dts_pkg::OP_KEY_RD_LAST: key_raddr = pcnt_m1[PI-1:0];
            dts_pkg::OP_KEY_RD_CONS: key_raddr = r_cons;
            dts_pkg::OP_CUR_TAKE:    key_raddr = r_fq;
            default:                 key_rd    = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == dts_pkg::OP_DECL_WR) m_key[r_pcnt[PI-1:0]] <= r_tgt;
        if (key_rd) r_kq <= m_key[key_raddr];
    end

    // dependency memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == dts_pkg::OP_DEP_WR) begin
            m_cons[r_dcnt[DI-1:0]] <= pcnt_m1[PI-1:0];
            m_ref[r_dcnt[DI-1:0]]  <= r_ref;
        end
        if (i_cmd.op == dts_pkg::OP_DEP_WR) begin
            m_prod[r_dcnt[DI-1:0]] <= '0;
        end else if (i_cmd.op == dts_pkg::OP_EDGE_WR) begin
            m_prod[r_s[DI-1:0]] <= {1'b1, r_p};
        end
        if (i_cmd.op == dts_pkg::OP_DEP_RD) begin
            r_cq <= m_cons[r_s[DI-1:0]];
            r_rq <= m_ref[r_s[DI-1:0]];
            r_pq <= m_prod[r_s[DI-1:0]];
        end
    end

    // in-degree memory and ready queue
    always_comb begin
        deg_rd     = 1'b1;
        deg_raddr  = r_i[PI-1:0];
        deg_we     = 1'b0;
        deg_waddr  = r_cons;
        deg_wdata  = '0;
        fifo_we    = 1'b0;
        fifo_wdata = r_i[PI-1:0];
        unique case (i_cmd.op)
            dts_pkg::OP_DEG_RD_CONS: deg_raddr = r_cons;
            dts_pkg::OP_DEG_RD_I:    deg_raddr = r_i[PI-1:0];
            dts_pkg::OP_DEG_RD_CQ:   deg_raddr = r_cq;
            default:                 deg_rd    = 1'b0;
        endcase
        unique case (i_cmd.op)
            dts_pkg::OP_DEG_CLR: begin
                deg_we    = 1'b1;
                deg_waddr = r_i[PI-1:0];
            end
            dts_pkg::OP_EDGE_WR: begin
                deg_we    = 1'b1;
                deg_wdata = r_dq + 1'b1;
            end
            dts_pkg::OP_DEC: begin
                deg_we     = (r_dq != '0);
                deg_wdata  = r_dq - 1'b1;
                fifo_we    = (r_dq == DEG_W'(1));
                fifo_wdata = r_cons;
            end
            dts_pkg::OP_FIFO_PUSH_I: fifo_we = (r_dq == '0);
            default:                 deg_we  = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (deg_we) m_deg[deg_waddr] <= deg_wdata;
        if (deg_rd) r_dq <= m_deg[deg_raddr];
        if (fifo_we) m_fifo[r_tail[PI-1:0]] <= fifo_wdata;
        if (i_cmd.op == dts_pkg::OP_FIFO_RD) r_fq <= m_fifo[r_head[PI-1:0]];
    end

    // result formation
    always_comb begin
        if (r_tgt == '0)  dep_code = dts_pkg::DIAG_REF_MISS;
        else if (!r_found) dep_code = dts_pkg::DIAG_UNKNOWN;
        else               dep_code = dts_pkg::DIAG_SELF;
    end

    always_comb begin
        e_kind = dts_pkg::KIND_DIAG;
        e_idx  = '0;
        e_key  = '0;
        e_code = dts_pkg::DIAG_NONE;
        e_slot = '0;
        e_err  = 1'b1;
        unique case (i_cmd.emit)
            dts_pkg::EM_OVF_DECL: begin
                e_key  = r_tgt;
                e_code = dts_pkg::DIAG_OVERFLOW;
            end
            dts_pkg::EM_ID_MISS: begin
                e_idx  = IW'(r_pcnt);
                e_code = dts_pkg::DIAG_ID_MISS;
            end
            dts_pkg::EM_DUP: begin
                e_idx  = IW'(r_pcnt);
                e_key  = r_tgt;
                e_code = dts_pkg::DIAG_DUP;
            end
            dts_pkg::EM_OVF_DEP: begin
                e_idx  = IW'(pcnt_m1);
                e_key  = r_kq;
                e_code = dts_pkg::DIAG_OVERFLOW;
            end
            dts_pkg::EM_DEP_DIAG: begin
                e_idx  = IW'(r_cons);
                e_key  = r_kq;
                e_code = dep_code;
                e_slot = SW'(r_s);
            end
            dts_pkg::EM_SCHED: begin
                e_kind = dts_pkg::KIND_SCHED;
                e_idx  = IW'(r_cur);
                e_key  = r_kq;
                e_err  = 1'b0;
            end
            dts_pkg::EM_CYCLE: e_code = dts_pkg::DIAG_CYCLE;
            dts_pkg::EM_LEFT: begin
                e_kind = dts_pkg::KIND_LEFT;
                e_idx  = IW'(r_i);
                e_key  = r_kq;
                e_err  = 1'b0;
            end
            dts_pkg::EM_SUMMARY: begin
                e_kind = dts_pkg::KIND_SUMMARY;
                e_err  = 1'b0;
            end
            default: e_err = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit != dts_pkg::EM_NONE) begin
            r_o_kind <= e_kind;
            r_o_idx  <= e_idx;
            r_o_key  <= e_key;
            r_o_code <= e_code;
            r_o_slot <= e_slot;
            r_o_cnt  <= (i_cmd.emit == dts_pkg::EM_SUMMARY) ? CW'(r_sched) : '0;
            r_o_ok   <= (i_cmd.emit == dts_pkg::EM_SUMMARY) && !r_err;
            r_o_last <= (i_cmd.emit == dts_pkg::EM_SUMMARY);
        end
    end

    // counters and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_pcnt    <= '0;
            r_dcnt    <= '0;
            r_err     <= 1'b0;
            r_found   <= 1'b0;
            r_i       <= '0;
            r_s       <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_sched   <= '0;
        end else begin
            if (i_cmd.emit != dts_pkg::EM_NONE) r_o_valid <= 1'b1;
            else if (o_out.ready)               r_o_valid <= 1'b0;

            if (fifo_we) r_tail <= r_tail + 1'b1;

            unique case (i_cmd.op)
                dts_pkg::OP_LOAD: begin
                    r_act   <= i_in.action;
                    r_tgt   <= i_in.pass_key;
                    r_ref   <= i_in.ref_key;
                    r_isout <= i_in.ref_is_pass_output;
                    r_i     <= '0;
                    r_s     <= '0;
                    r_found <= 1'b0;
                    r_head  <= '0;
                    r_tail  <= '0;
                    r_sched <= '0;
                end
                dts_pkg::OP_KEY_SCAN_CMP: begin
                    if (r_kq == r_tgt) begin
                        r_found <= 1'b1;
                        r_p     <= r_i[PI-1:0];
                    end
                    r_i <= r_i + 1'b1;
                end
                dts_pkg::OP_DECL_WR: r_pcnt <= r_pcnt + 1'b1;
                dts_pkg::OP_DEP_WR:  r_dcnt <= r_dcnt + 1'b1;
                dts_pkg::OP_DEP_TAKE: begin
                    r_cons  <= r_cq;
                    r_tgt   <= r_rq;
                    r_i     <= '0;
                    r_found <= 1'b0;
                end
                dts_pkg::OP_S_ZERO:      r_s <= '0;
                dts_pkg::OP_S_INC:       r_s <= r_s + 1'b1;
                dts_pkg::OP_I_ZERO:      r_i <= '0;
                dts_pkg::OP_DEG_CLR,
                dts_pkg::OP_FIFO_PUSH_I,
                dts_pkg::OP_I_INC:       r_i <= r_i + 1'b1;
                dts_pkg::OP_FIFO_RD:     r_head <= r_head + 1'b1;
                dts_pkg::OP_CUR_TAKE:    r_cur <= r_fq;
                dts_pkg::OP_DEG_RD_CQ:   r_cons <= r_cq;
                dts_pkg::OP_DEC:         r_s <= r_s + 1'b1;
                default: ;
            endcase

            if (e_err) r_err <= 1'b1;
            unique case (i_cmd.emit)
                dts_pkg::EM_SCHED: begin
                    r_sched <= r_sched + 1'b1;
                    r_s     <= '0;
                end
                dts_pkg::EM_CYCLE: r_i <= '0;
                dts_pkg::EM_LEFT:  r_i <= r_i + 1'b1;
                dts_pkg::EM_SUMMARY: begin
                    r_pcnt <= '0;
                    r_dcnt <= '0;
                    r_err  <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // status
    always_comb begin
        o_status.in_fire      = i_in.valid && i_cmd.in_ready;
        o_status.act          = r_act;
        o_status.is_out       = r_isout;
        o_status.pcnt_zero    = (r_pcnt == '0);
        o_status.pcnt_full    = (r_pcnt == (PI+1)'(MAX_PASSES));
        o_status.dcnt_full    = (r_dcnt == (DI+1)'(MAX_DEPS));
        o_status.tgt_zero     = (r_tgt == '0);
        o_status.i_lt_p       = (r_i < r_pcnt);
        o_status.found        = r_found;
        o_status.p_eq_cons    = (r_p == r_cons);
        o_status.s_lt_d       = (r_s < r_dcnt);
        o_status.rq_zero      = (r_rq == '0);
        o_status.head_lt_tail = (r_head < r_tail);
        o_status.sched_lt_p   = (r_sched < r_pcnt);
        o_status.edge_hit     = r_pq[PI] && (r_pq[PI-1:0] == r_cur);
        o_status.dq_nz        = (r_dq != '0);
        o_status.out_free     = out_free;
    end

    assign i_in.ready            = i_cmd.in_ready;
    assign o_out.valid           = r_o_valid;
    assign o_out.kind            = r_o_kind;
    assign o_out.pass_index      = r_o_idx;
    assign o_out.pass_key_out    = r_o_key;
    assign o_out.diag_code       = r_o_code;
    assign o_out.dep_slot        = r_o_slot;
    assign o_out.scheduled_count = r_o_cnt;
    assign o_out.success         = r_o_ok;
    assign o_out.last            = r_o_last;
endmodule

// ===== hw/rtl/dependency_topological_scheduler_top.sv =====
// top level of the dependency scheduler: controller plus datapath
// depends on dts_pkg, dts_in_if, dts_out_if, dts_ctrl and dts_dp
//
// channel  | dir | beat fields
// ---------+-----+-------------------------------------------------------------
// i_in     | in  | action, pass_key, ref_key, ref_is_pass_output
// o_out    | out | kind, pass_index, pass_key_out, diag_code, dep_slot,
//          |     | scheduled_count, success, last
//
// one request beat at a time; ready is high only while the controller is idle
// declare: the key table is scanned one entry at a time through its single read port
// finish: the one-port key, dependency and in-degree memories are walked one entry at a time
// synchronous active-low reset clears the counters and the output valid flag; the
//   in-degree table is cleared entry by entry at the start of every finish
// a stalled output holds its beat; the controller waits in its emit state
module dependency_topological_scheduler_top #(
    parameter int MAX_PASSES = dts_pkg::MAX_PASSES_DEF,
    parameter int MAX_DEPS   = dts_pkg::MAX_DEPS_DEF,
    parameter int KEY_BITS   = dts_pkg::KEY_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dts_in_if.sink    i_in,
    dts_out_if.source o_out
);
    // command and status between controller and datapath
    dts_pkg::t_cmd    cmd;
    dts_pkg::t_status status;

    dts_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    dts_dp #(
        .MAX_PASSES (MAX_PASSES),
        .MAX_DEPS   (MAX_DEPS),
        .KEY_BITS   (KEY_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_out    (o_out),
        .i_cmd    (cmd),
        .o_status (status)
    );

    // a result is formed only when the output register can take it
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit != dts_pkg::EM_NONE |-> status.out_free)
        else $error("result formed over a pending beat");

    // no result is formed while requests are taken
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> cmd.emit == dts_pkg::EM_NONE)
        else $error("result formed while idle");

    // after a request beat the block is busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("request taken twice in a row");

    // the closing flag rides only on the summary
    a_last_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.last |-> o_out.kind == dts_pkg::KIND_SUMMARY)
        else $error("last on a non-summary beat");
endmodule
